// ----- hdl/resp_command_parser_assert.svh -----
// assertion macros for the resp command parser checker
// needs clk and rst in the scope where a macro is used
`ifndef RESP_COMMAND_PARSER_ASSERT_SVH
`define RESP_COMMAND_PARSER_ASSERT_SVH

// property checked on every clock, switched off while in reset
`define RCP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock, reset included
`define RCP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/rcp_pkg.sv -----
// shared types, codes and constants of the resp command parser
// no dependencies; imported by every module of the parser
package rcp_pkg;

  // limits and field widths
  localparam int ARG_LIMIT_CAP  = 1024;
  localparam int BULK_LIMIT_CAP = 64 * 1024 * 1024;
  localparam int ARGS_W         = 11;
  localparam int IDX_W          = 10;
  localparam int ACCUM_W        = 27;
  localparam int MAC_W          = ACCUM_W + 4;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 27;

  // word queue between front and back, depth a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ARG_LIMIT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BULK_LIMIT = CFG_IDX_W'(1);

  // characters of the protocol
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [2:0] {
    CL_STAR,
    CL_DOLLAR,
    CL_CR,
    CL_LF,
    CL_MINUS,
    CL_DIGIT,
    CL_OTHER
  } cls_t;

  // one classified input byte
  typedef struct packed {
    logic [7:0] data;
    cls_t       cls;
    logic [3:0] digit;
  } tok_t;

  // configured limits handed to the back end
  typedef struct packed {
    logic [ARGS_W-1:0]  arg_limit;
    logic [ACCUM_W-1:0] bulk_limit;
  } lim_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_MISSING_STAR   = 3'd0,
    ERR_BAD_COUNT      = 3'd1,
    ERR_TOO_MANY_ARGS  = 3'd2,
    ERR_MISSING_DOLLAR = 3'd3,
    ERR_BAD_LENGTH     = 3'd4,
    ERR_BULK_TOO_LARGE = 3'd5,
    ERR_MISSING_CRLF   = 3'd6
  } err_t;

endpackage

// ----- hdl/rcp_front.sv -----
// front end: takes input words, classifies each byte and registers it
// depends on rcp_pkg; feeds rcp_queue
module rcp_front (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [7:0]   data_byte,
  input  logic         q_full,
  output logic         q_push,
  output rcp_pkg::tok_t q_data
);
  import rcp_pkg::*;

  logic tok_valid;
  tok_t tok;
  tok_t tok_next;
  logic accept;

  // hold off the source only while a word waits on a full queue
  assign in_stall = tok_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = tok_valid && !q_full;
  assign q_data   = tok;

  // byte classification
  always_comb begin
    tok_next.data  = data_byte;
    tok_next.digit = 4'(data_byte - CH_ZERO);
    if (data_byte == CH_STAR) begin
      tok_next.cls = CL_STAR;
    end else if (data_byte == CH_DOLLAR) begin
      tok_next.cls = CL_DOLLAR;
    end else if (data_byte == CH_CR) begin
      tok_next.cls = CL_CR;
    end else if (data_byte == CH_LF) begin
      tok_next.cls = CL_LF;
    end else if (data_byte == CH_MINUS) begin
      tok_next.cls = CL_MINUS;
    end else if (data_byte inside {[CH_ZERO:CH_NINE]}) begin
      tok_next.cls = CL_DIGIT;
    end else begin
      tok_next.cls = CL_OTHER;
    end
  end

  // classified word register
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else begin
      tok_valid <= accept || (tok_valid && q_full);
    end
    if (accept) begin
      tok <= tok_next;
    end
  end

endmodule

// ----- hdl/rcp_queue.sv -----
// short word queue between front and back end
// depends on rcp_pkg for the word type and depth
module rcp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rcp_pkg::tok_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output rcp_pkg::tok_t head
);
  import rcp_pkg::*;

  tok_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full  = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (QUEUE_AW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QUEUE_AW + 1)'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- hdl/rcp_back.sv -----
// back end: protocol state machine and result word register
// depends on rcp_pkg; pops classified words from rcp_queue
module rcp_back (
  input  logic                       clk,
  input  logic                       rst,
  input  rcp_pkg::lim_t              lim,
  input  logic                       q_empty,
  input  rcp_pkg::tok_t              q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output rcp_pkg::kind_t             kind,
  output logic [7:0]                 payload_byte,
  output logic [rcp_pkg::IDX_W-1:0]  arg_index,
  output logic                       last_of_command,
  output rcp_pkg::err_t              error_code
);
  import rcp_pkg::*;

  typedef enum logic [3:0] {
    PH_STAR,
    PH_COUNT,
    PH_COUNT_LF,
    PH_DOLLAR,
    PH_LEN,
    PH_LEN_LF,
    PH_PAYLOAD,
    PH_PAY_CR,
    PH_PAY_LF,
    PH_DISCARD
  } phase_t;

  localparam logic [MAC_W-1:0] COUNT_SAT = MAC_W'(ARG_LIMIT_CAP + 1);
  localparam logic [MAC_W-1:0] LEN_SAT   = MAC_W'(BULK_LIMIT_CAP + 1);
  localparam logic [ARGS_W-1:0]  ARG_CAP  = ARGS_W'(ARG_LIMIT_CAP);
  localparam logic [ACCUM_W-1:0] BULK_CAP = ACCUM_W'(BULK_LIMIT_CAP);

  // state
  phase_t             phase, phase_next;
  logic [ACCUM_W-1:0] number_accum, number_accum_next;
  logic               number_negative, number_negative_next;
  logic               number_bad, number_bad_next;
  logic               digit_seen, digit_seen_next;
  logic [ARGS_W-1:0]  args_expected, args_expected_next;
  logic [ARGS_W-1:0]  args_finished, args_finished_next;
  logic [ACCUM_W-1:0] payload_left, payload_left_next;

  // step results
  logic             emit;
  kind_t            res_kind;
  logic [IDX_W-1:0] res_idx;
  logic             res_last;
  err_t             res_err;
  logic             do_error;
  logic             do_start;

  // helpers
  logic [ARGS_W-1:0]  alim;
  logic [ACCUM_W-1:0] blim;
  logic [MAC_W-1:0]   mac;
  logic [MAC_W-1:0]   sat;
  logic [ACCUM_W-1:0] accum_sat;
  logic [ARGS_W-1:0]  fin_inc;
  logic [ACCUM_W-1:0] left_dec;
  logic               out_free;

  assign out_free = !out_valid || !out_stall;
  assign q_pop    = !q_empty && out_free;

  // effective limits
  assign alim = (lim.arg_limit < ARG_CAP) ? lim.arg_limit : ARG_CAP;
  assign blim = (lim.bulk_limit < BULK_CAP) ? lim.bulk_limit : BULK_CAP;

  // decimal accumulate with saturation above the cap
  assign mac = (MAC_W'(number_accum) << 3) + (MAC_W'(number_accum) << 1)
             + MAC_W'(q_head.digit);
  assign sat       = (phase == PH_COUNT) ? COUNT_SAT : LEN_SAT;
  assign accum_sat = (mac > sat) ? sat[ACCUM_W-1:0] : mac[ACCUM_W-1:0];
  assign fin_inc   = args_finished + ARGS_W'(1);
  assign left_dec  = payload_left - ACCUM_W'(1);

  // next state for the word at the queue head
  always_comb begin
    phase_next           = phase;
    number_accum_next    = number_accum;
    number_negative_next = number_negative;
    number_bad_next      = number_bad;
    digit_seen_next      = digit_seen;
    args_expected_next   = args_expected;
    args_finished_next   = args_finished;
    payload_left_next    = payload_left;
    emit     = 1'b0;
    res_kind = KIND_PAYLOAD;
    res_idx  = args_finished[IDX_W-1:0];
    res_last = 1'b0;
    res_err  = ERR_MISSING_STAR;
    do_error = 1'b0;
    do_start = 1'b0;

    case (phase)
      PH_STAR: begin
        if (q_head.cls == CL_STAR) begin
          do_start = 1'b1;
        end else begin
          do_error = 1'b1;
          res_err  = ERR_MISSING_STAR;
          res_idx  = '0;
        end
      end
      PH_COUNT, PH_LEN: begin
        if (q_head.cls == CL_CR) begin
          phase_next = (phase == PH_COUNT) ? PH_COUNT_LF : PH_LEN_LF;
        end else if (q_head.cls == CL_MINUS && !digit_seen && !number_negative) begin
          number_negative_next = 1'b1;
        end else if (q_head.cls == CL_DIGIT) begin
          digit_seen_next   = 1'b1;
          number_accum_next = accum_sat;
        end else begin
          number_bad_next = 1'b1;
        end
      end
      PH_COUNT_LF: begin
        res_idx = '0;
        if (q_head.cls != CL_LF || number_bad || !digit_seen || number_negative
            || number_accum == '0) begin
          do_error = 1'b1;
          res_err  = ERR_BAD_COUNT;
        end else if (number_accum > ACCUM_W'(alim)) begin
          do_error = 1'b1;
          res_err  = ERR_TOO_MANY_ARGS;
        end else begin
          args_expected_next = number_accum[ARGS_W-1:0];
          args_finished_next = '0;
          phase_next         = PH_DOLLAR;
        end
      end
      PH_DOLLAR: begin
        if (q_head.cls != CL_DOLLAR) begin
          do_error = 1'b1;
          res_err  = ERR_MISSING_DOLLAR;
        end else begin
          number_accum_next    = '0;
          number_negative_next = 1'b0;
          number_bad_next      = 1'b0;
          digit_seen_next      = 1'b0;
          phase_next           = PH_LEN;
        end
      end
      PH_LEN_LF: begin
        if (q_head.cls != CL_LF || number_bad || !digit_seen
            || (number_negative && number_accum != '0)) begin
          do_error = 1'b1;
          res_err  = ERR_BAD_LENGTH;
        end else if (number_accum > blim) begin
          do_error = 1'b1;
          res_err  = ERR_BULK_TOO_LARGE;
        end else begin
          payload_left_next = number_accum;
          phase_next = (number_accum != '0) ? PH_PAYLOAD : PH_PAY_CR;
        end
      end
      PH_PAYLOAD: begin
        payload_left_next = left_dec;
        if (left_dec == '0) begin
          phase_next = PH_PAY_CR;
        end
        emit     = 1'b1;
        res_kind = KIND_PAYLOAD;
      end
      PH_PAY_CR: begin
        if (q_head.cls != CL_CR) begin
          do_error = 1'b1;
          res_err  = ERR_MISSING_CRLF;
        end else begin
          phase_next = PH_PAY_LF;
        end
      end
      PH_PAY_LF: begin
        if (q_head.cls != CL_LF) begin
          do_error = 1'b1;
          res_err  = ERR_MISSING_CRLF;
        end else begin
          args_finished_next = fin_inc;
          res_last   = (fin_inc >= args_expected);
          phase_next = res_last ? PH_STAR : PH_DOLLAR;
          emit       = 1'b1;
          res_kind   = KIND_DONE;
        end
      end
      default: begin
        if (q_head.cls == CL_STAR) begin
          do_start = 1'b1;
        end else begin
          phase_next = PH_DISCARD;
        end
      end
    endcase

    // error result, then drop bytes until a star
    if (do_error) begin
      phase_next = PH_DISCARD;
      emit       = 1'b1;
      res_kind   = KIND_ERROR;
    end

    // star opens a new command
    if (do_start) begin
      number_accum_next    = '0;
      number_negative_next = 1'b0;
      number_bad_next      = 1'b0;
      digit_seen_next      = 1'b0;
      args_expected_next   = '0;
      args_finished_next   = '0;
      payload_left_next    = '0;
      phase_next           = PH_COUNT;
    end
  end

  // state and result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_STAR;
      number_accum    <= '0;
      number_negative <= 1'b0;
      number_bad      <= 1'b0;
      digit_seen      <= 1'b0;
      args_expected   <= '0;
      args_finished   <= '0;
      payload_left    <= '0;
      out_valid       <= 1'b0;
      kind            <= KIND_PAYLOAD;
      payload_byte    <= '0;
      arg_index       <= '0;
      last_of_command <= 1'b0;
      error_code      <= ERR_MISSING_STAR;
    end else begin
      if (q_pop) begin
        phase           <= phase_next;
        number_accum    <= number_accum_next;
        number_negative <= number_negative_next;
        number_bad      <= number_bad_next;
        digit_seen      <= digit_seen_next;
        args_expected   <= args_expected_next;
        args_finished   <= args_finished_next;
        payload_left    <= payload_left_next;
      end
      if (q_pop && emit) begin
        out_valid       <= 1'b1;
        kind            <= res_kind;
        payload_byte    <= (res_kind == KIND_PAYLOAD) ? q_head.data : 8'd0;
        arg_index       <= res_idx;
        last_of_command <= res_last;
        error_code      <= (res_kind == KIND_ERROR) ? res_err : ERR_MISSING_STAR;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/resp_command_parser.sv -----
// top level of the resp multibulk command parser
// depends on rcp_pkg, rcp_front, rcp_queue and rcp_back
//
//   channel  handshake            payload
//   in       in_valid / in_stall  data_byte
//   out      out_valid/ out_stall kind, payload_byte, arg_index,
//                                 last_of_command, error_code
//   cfg      cfg_valid/ cfg_ready cfg_index, cfg_data
//
// one byte per clock sustained while out_stall stays low; a result word is
// registered after its byte passes the front-end word register, the queue
// write and the back-end result register. the back-end state machine retires one queued word per cycle unless stalled.
// synchronous reset restores the limit registers and empties the queue.
// a stalled output holds the back end; the four-word queue then fills and
// in_stall rises. cfg_ready is always high.
module resp_command_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      data_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rcp_pkg::kind_t                  kind,
  output logic [7:0]                      payload_byte,
  output logic [rcp_pkg::IDX_W-1:0]       arg_index,
  output logic                            last_of_command,
  output rcp_pkg::err_t                   error_code,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rcp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rcp_pkg::*;

  lim_t lim;
  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  tok_t q_data;
  tok_t q_head;

  assign cfg_ready = 1'b1;

  // limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lim.arg_limit  <= ARGS_W'(ARG_LIMIT_CAP);
      lim.bulk_limit <= ACCUM_W'(BULK_LIMIT_CAP);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_ARG_LIMIT) begin
        lim.arg_limit <= cfg_data[ARGS_W-1:0];
      end else if (cfg_index == CFG_BULK_LIMIT) begin
        lim.bulk_limit <= cfg_data[ACCUM_W-1:0];
      end
    end
  end

  rcp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  rcp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  rcp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .lim             (lim),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .payload_byte    (payload_byte),
    .arg_index       (arg_index),
    .last_of_command (last_of_command),
    .error_code      (error_code)
  );

endmodule

// ----- hdl/rcp_checker.sv -----
// port-level checks for the resp command parser, bound to the top level
// depends on rcp_pkg and resp_command_parser_assert.svh
`include "resp_command_parser_assert.svh"

module rcp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input rcp_pkg::kind_t              kind,
  input logic [7:0]                  payload_byte,
  input logic [rcp_pkg::IDX_W-1:0]   arg_index,
  input logic                        last_of_command,
  input rcp_pkg::err_t               error_code
);
  import rcp_pkg::*;

  // a stalled result word holds
  `RCP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(kind) && $stable(payload_byte) && $stable(arg_index) && $stable(error_code), "result word changed while stalled")

  // payload byte is zero on anything but a payload word
  `RCP_ASSERT(a_payload_zero, out_valid && kind != KIND_PAYLOAD |-> payload_byte == 8'd0, "payload byte set on non-payload word")

  // last flag only on an argument-complete word
  `RCP_ASSERT(a_last_done, out_valid && last_of_command |-> kind == KIND_DONE, "last flag on wrong word kind")

  // no result word right after reset
  `RCP_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid, "result valid after reset")

endmodule

bind resp_command_parser rcp_checker u_rcp_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .kind            (kind),
  .payload_byte    (payload_byte),
  .arg_index       (arg_index),
  .last_of_command (last_of_command),
  .error_code      (error_code)
);
